>>> rtl/skdh_pkg.sv
// shared types, constants and helper functions for the sector key derivation core
// sha-256 round constants, salts, block layout constants, command/status structs
// no dependencies
package skdh_pkg;

    // which 512-bit message block the datapath presents to the hash unit
    typedef enum logic [2:0] {
        BK_IPAD = 3'd0,
        BK_OPAD = 3'd1,
        BK_UID  = 3'd2,
        BK_INFO = 3'd3,
        BK_DIG  = 3'd4
    } t_blk;

    // hmac key source
    typedef enum logic [1:0] {
        KS_SALT_A = 2'd0,
        KS_SALT_B = 2'd1,
        KS_PRK_A  = 2'd2,
        KS_PRK_B  = 2'd3
    } t_key;

    // where a finished digest goes
    typedef enum logic [2:0] {
        SV_NONE  = 3'd0,
        SV_INNER = 3'd1,
        SV_PRK_A = 3'd2,
        SV_PRK_B = 3'd3,
        SV_KEY_A = 3'd4,
        SV_KEY_B = 3'd5
    } t_save;

    typedef struct packed {
        logic       accept;
        logic       start;
        logic       init;
        t_blk       blk;
        t_key       key;
        t_save      save;
        logic       emit;
        logic       last;
        logic [5:0] sector;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
        logic out_busy;
    } t_dp_sts;

    localparam logic [31:0] SHA_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // salts, left aligned in a zero-padded 64-byte key block
    localparam logic [511:0] SALT_A_BLK = {
        200'h536e61706d616b65725f71776572747975696f705b2c2e3b5d, 312'h0
    };
    localparam logic [511:0] SALT_B_BLK = {
        256'h536e61706d616b65725f71776572747975696f705b2c2e3b5d5f317132773365,
        256'h0
    };

    localparam logic [7:0]  IPAD_BYTE    = 8'h36;
    localparam logic [7:0]  OPAD_BYTE    = 8'h5c;
    localparam logic [7:0]  PAD_BYTE     = 8'h80;
    localparam logic [7:0]  INFO_END     = 8'h01;
    localparam logic [31:0] INFO_PREFIX  = 32'h6b65795f;
    localparam logic [7:0]  CH_A         = 8'h61;
    localparam logic [7:0]  CH_B         = 8'h62;
    localparam logic [7:0]  CH_SEP       = 8'h5f;
    localparam logic [7:0]  CH_ZERO      = 8'h30;
    localparam logic [63:0] UID_LEN_BITS = 64'd544;
    localparam logic [63:0] DIG_LEN_BITS = 64'd768;
    localparam logic [63:0] INFO8_BITS   = 64'd576;
    localparam logic [63:0] INFO9_BITS   = 64'd584;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] sml_s0(input logic [31:0] x);
        sml_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml_s1(input logic [31:0] x);
        sml_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // tens and units of a small sector number, tens in the upper nibble
    function automatic logic [7:0] dec_split(input logic [5:0] s);
        logic [3:0] t;
        logic [5:0] r;
        t = 4'd0;
        r = s;
        for (int i = 0; i < 6; i++) begin
            if (r >= 6'd10) begin
                r = r - 6'd10;
                t = t + 4'd1;
            end
        end
        dec_split = {t, r[3:0]};
    endfunction

endpackage

>>> rtl/sector_key_derivation_hkdf_core.sv
// top level: per-sector key derivation, hkdf over hmac-sha256
// depends on skdh_pkg, skdh_ctrl, skdh_datapath (which holds skdh_sha_core)
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------
//  input   | i_valid / o_stall  | i_card_uid[31:0], i_derive_b
//  output  | o_valid / i_stall  | o_sector_index[3:0], o_key_a[47:0],
//          |                    | o_key_b[47:0], o_last_sector
//
// one sha-256 compression is a load, 64 rounds and a feed-forward add;
// one hmac is four compressions; b keys are derived only when i_derive_b is set
// (16 sectors by default); all hmacs share the single round unit, which takes
// one item at a time: o_stall stays high from acceptance until the last sector is
// loaded into the output register
// a result waits in the output register while i_stall is high; the next sector's
// hashing carries on meanwhile
// synchronous active-low reset clears the controller, the hash unit's round
// sequencing and output valid; data registers are not reset
module sector_key_derivation_hkdf_core import skdh_pkg::*; #(
    parameter int NUM_SECTORS = 16,
    parameter int KEY_BYTES   = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_card_uid,
    input  logic        i_derive_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_sector_index,
    output logic [47:0] o_key_a,
    output logic [47:0] o_key_b,
    output logic        o_last_sector
);

    // command and status between sequencer and datapath
    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: extract a, optional extract b, then expand per sector
    skdh_ctrl #(
        .NUM_SECTORS (NUM_SECTORS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_derive_b (i_derive_b),
        .o_stall    (o_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // block builder, hash unit and result register
    skdh_datapath #(
        .KEY_BYTES (KEY_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_card_uid     (i_card_uid),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_sector_index (o_sector_index),
        .o_key_a        (o_key_a),
        .o_key_b        (o_key_b),
        .o_last_sector  (o_last_sector)
    );

endmodule

>>> rtl/skdh_sha_core.sv
// sha-256 compression unit, one round per clock
// depends on skdh_pkg
module skdh_sha_core import skdh_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic         i_init,
    input  logic [511:0] i_block,
    output logic         o_done,
    output logic [255:0] o_digest
);

    logic [31:0] r_w [0:15];
    logic [31:0] r_v [0:7];
    logic [31:0] r_h [0:7];
    logic [5:0]  r_rnd;
    logic        r_busy;
    logic        r_fin;
    logic        r_done;

    logic [31:0] t1, t2, w_new;

    always_comb begin
        t1 = r_v[7] + big_s1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
           + SHA_K[r_rnd] + r_w[0];
        t2 = big_s0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        w_new = sml_s1(r_w[14]) + r_w[9] + sml_s0(r_w[1]) + r_w[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= 6'd0;
        end else begin
            r_done <= r_fin;
            r_fin  <= r_busy && !i_start && (r_rnd == 6'd63);
            if (i_start) begin
                r_busy <= 1'b1;
                r_rnd  <= 6'd0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int i = 0; i < 16; i++) r_w[i] <= i_block[511 - 32*i -: 32];
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= i_init ? SHA_IV[i] : r_h[i];
                if (i_init) r_h[i] <= SHA_IV[i];
            end
        end else if (r_busy) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
            for (int i = 1; i < 8; i++) r_v[i] <= r_v[i-1];
            r_v[4] <= r_v[3] + t1;
            r_v[0] <= t1 + t2;
        end else if (r_fin) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
        end
    end

    assign o_done   = r_done;
    assign o_digest = {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4], r_h[5], r_h[6], r_h[7]};

endmodule

>>> rtl/skdh_datapath.sv
// datapath: message block builder, hash unit, key and result registers
// depends on skdh_pkg and skdh_sha_core
module skdh_datapath import skdh_pkg::*; #(
    parameter int KEY_BYTES = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic [31:0] i_card_uid,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [3:0]  o_sector_index,
    output logic [47:0] o_key_a,
    output logic [47:0] o_key_b,
    output logic        o_last_sector
);

    localparam int KEEP      = (KEY_BYTES > 6) ? 6 : KEY_BYTES;
    localparam int KEY_SHIFT = 8 * (6 - KEEP);

    logic [31:0]  r_uid;
    logic [255:0] r_prk_a, r_prk_b, r_inner;
    logic [47:0]  r_ka, r_kb;
    logic [47:0]  r_o_ka, r_o_kb;
    logic [3:0]   r_o_idx;
    logic         r_o_last;
    logic         r_ovalid;

    logic [511:0] key_blk, blk;
    logic [7:0]   digs;
    logic [7:0]   letter;
    logic [79:0]  info;
    logic [63:0]  info_len;
    logic         sha_done;
    logic [255:0] digest;
    logic [47:0]  trim;

    always_comb begin
        case (i_cmd.key)
            KS_SALT_A: key_blk = SALT_A_BLK;
            KS_SALT_B: key_blk = SALT_B_BLK;
            KS_PRK_A:  key_blk = {r_prk_a, 256'h0};
            KS_PRK_B:  key_blk = {r_prk_b, 256'h0};
            default:   key_blk = '0;
        endcase

        digs   = dec_split(i_cmd.sector);
        letter = (i_cmd.key == KS_PRK_B) ? CH_B : CH_A;
        if (digs[7:4] == 4'd0) begin
            info     = {INFO_PREFIX, letter, CH_SEP, CH_ZERO + {4'h0, digs[3:0]},
                        INFO_END, PAD_BYTE, 8'h00};
            info_len = INFO8_BITS;
        end else begin
            info     = {INFO_PREFIX, letter, CH_SEP, CH_ZERO + {4'h0, digs[7:4]},
                        CH_ZERO + {4'h0, digs[3:0]}, INFO_END, PAD_BYTE};
            info_len = INFO9_BITS;
        end

        case (i_cmd.blk)
            BK_IPAD: blk = key_blk ^ {64{IPAD_BYTE}};
            BK_OPAD: blk = key_blk ^ {64{OPAD_BYTE}};
            BK_UID:  blk = {r_uid, PAD_BYTE, 408'h0, UID_LEN_BITS};
            BK_INFO: blk = {info, 368'h0, info_len};
            BK_DIG:  blk = {r_inner, PAD_BYTE, 184'h0, DIG_LEN_BITS};
            default: blk = '0;
        endcase
    end

    skdh_sha_core u_sha (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.start),
        .i_init   (i_cmd.init),
        .i_block  (blk),
        .o_done   (sha_done),
        .o_digest (digest)
    );

    // first key bytes, right aligned when fewer than six are kept
    assign trim = digest[255 -: 48] >> KEY_SHIFT;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_uid <= i_card_uid;
            r_kb  <= 48'h0;
        end
        case (i_cmd.save)
            SV_INNER: r_inner <= digest;
            SV_PRK_A: r_prk_a <= digest;
            SV_PRK_B: r_prk_b <= digest;
            SV_KEY_A: r_ka    <= trim;
            SV_KEY_B: r_kb    <= trim;
            default: ;
        endcase
        if (i_cmd.emit) begin
            r_o_idx  <= i_cmd.sector[3:0];
            r_o_ka   <= r_ka;
            r_o_kb   <= r_kb;
            r_o_last <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (r_ovalid && !i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_sts.done     = sha_done;
    assign o_sts.out_busy = r_ovalid && i_stall;

    assign o_valid        = r_ovalid;
    assign o_sector_index = r_o_idx;
    assign o_key_a        = r_o_ka;
    assign o_key_b        = r_o_kb;
    assign o_last_sector  = r_o_last;

endmodule

>>> rtl/skdh_ctrl.sv
// controller: sequences hmac steps for extract and per-sector expand
// depends on skdh_pkg
module skdh_ctrl import skdh_pkg::*; #(
    parameter int NUM_SECTORS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_derive_b,
    output logic    o_stall,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam int SW = (NUM_SECTORS > 1) ? $clog2(NUM_SECTORS) : 1;
    localparam logic [SW-1:0] LAST_SEC = SW'(NUM_SECTORS - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_WAIT  = 5'b00100,
        S_NEXT  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        JB_EXT_A = 2'd0,
        JB_EXT_B = 2'd1,
        JB_EXP_A = 2'd2,
        JB_EXP_B = 2'd3
    } t_job;

    t_state        r_state, n_state;
    t_job          r_job, n_job;
    logic [1:0]    r_step, n_step;
    logic [SW-1:0] r_sec, n_sec;
    logic          r_want_b, n_want_b;
    t_key          key;
    t_save         dest;

    always_comb begin
        case (r_job)
            JB_EXT_A: begin key = KS_SALT_A; dest = SV_PRK_A; end
            JB_EXT_B: begin key = KS_SALT_B; dest = SV_PRK_B; end
            JB_EXP_A: begin key = KS_PRK_A;  dest = SV_KEY_A; end
            JB_EXP_B: begin key = KS_PRK_B;  dest = SV_KEY_B; end
            default:  begin key = KS_SALT_A; dest = SV_NONE;  end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_job    = r_job;
        n_step   = r_step;
        n_sec    = r_sec;
        n_want_b = r_want_b;

        o_cmd        = '0;
        o_cmd.key    = key;
        o_cmd.blk    = BK_IPAD;
        o_cmd.save   = SV_NONE;
        o_cmd.sector = 6'(r_sec);

        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_valid;
                if (i_valid) begin
                    n_want_b = i_derive_b;
                    n_job    = JB_EXT_A;
                    n_step   = 2'd0;
                    n_sec    = '0;
                    n_state  = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.start = 1'b1;
                o_cmd.init  = (r_step == 2'd0) || (r_step == 2'd2);
                case (r_step)
                    2'd0:    o_cmd.blk = BK_IPAD;
                    2'd1:    o_cmd.blk = (r_job == JB_EXT_A || r_job == JB_EXT_B)
                                         ? BK_UID : BK_INFO;
                    2'd2:    o_cmd.blk = BK_OPAD;
                    default: o_cmd.blk = BK_DIG;
                endcase
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.done) n_state = S_NEXT;
            end
            S_NEXT: begin
                if (r_step == 2'd1)      o_cmd.save = SV_INNER;
                else if (r_step == 2'd3) o_cmd.save = dest;
                if (r_step != 2'd3) begin
                    n_step  = r_step + 2'd1;
                    n_state = S_ISSUE;
                end else begin
                    n_step  = 2'd0;
                    n_state = S_ISSUE;
                    case (r_job)
                        JB_EXT_A: n_job = r_want_b ? JB_EXT_B : JB_EXP_A;
                        JB_EXT_B: n_job = JB_EXP_A;
                        JB_EXP_A: begin
                            if (r_want_b) n_job = JB_EXP_B;
                            else          n_state = S_EMIT;
                        end
                        default:  n_state = S_EMIT;
                    endcase
                end
            end
            S_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = (r_sec == LAST_SEC);
                    if (r_sec == LAST_SEC) begin
                        n_state = S_IDLE;
                    end else begin
                        n_sec   = r_sec + SW'(1);
                        n_job   = JB_EXP_A;
                        n_step  = 2'd0;
                        n_state = S_ISSUE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_job    <= JB_EXT_A;
            r_step   <= 2'd0;
            r_sec    <= '0;
            r_want_b <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_job    <= n_job;
            r_step   <= n_step;
            r_sec    <= n_sec;
            r_want_b <= n_want_b;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule
